// File: hdl/ckwc_pkg.sv
// ----------------------------------------------------------------------------
// ckwc_pkg
// shared types, constants and keyword table of the c source keyword counter
// ----------------------------------------------------------------------------
package ckwc_pkg;

    // fixed widths of the result fields
    localparam int KIND_W    = 2;
    localparam int OUT_IDX_W = 4;
    localparam int OUT_CNT_W = 16;
    localparam int OUT_LEN_W = 7;
    localparam int KW_SLOTS  = 16;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_WORD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPORT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

    // characters the lexer looks for
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_UNDER   = 8'h5f;

    // lexer modes, one-hot
    typedef enum logic [6:0] {
        MODE_NORMAL = 7'b0000001,
        MODE_SLASH  = 7'b0000010,
        MODE_LINE   = 7'b0000100,
        MODE_BLOCK  = 7'b0001000,
        MODE_STAR   = 7'b0010000,
        MODE_STRING = 7'b0100000,
        MODE_HASH   = 7'b1000000
    } lex_mode_t;

    // identifier that ended in the current transaction
    typedef struct packed {
        logic                 done;
        logic                 hit;
        logic [OUT_IDX_W-1:0] idx;
        logic [OUT_LEN_W-1:0] len;
    } word_info_t;

    // keyword text, first character in the highest used byte
    function automatic logic [63:0] kw_word(input logic [3:0] k);
        logic [63:0] w;
        case (k)
            4'd0:    w = 64'("auto");
            4'd1:    w = 64'("break");
            4'd2:    w = 64'("case");
            4'd3:    w = 64'("char");
            4'd4:    w = 64'("const");
            4'd5:    w = 64'("continue");
            4'd6:    w = 64'("default");
            4'd7:    w = 64'("unsigned");
            4'd8:    w = 64'("void");
            4'd9:    w = 64'("volatile");
            4'd10:   w = 64'("while");
            default: w = 64'h0;
        endcase
        return w;
    endfunction

    // keyword length, zero for empty slots
    function automatic logic [3:0] kw_len(input logic [3:0] k);
        logic [3:0] l;
        case (k)
            4'd0:    l = 4'd4;
            4'd1:    l = 4'd5;
            4'd2:    l = 4'd4;
            4'd3:    l = 4'd4;
            4'd4:    l = 4'd5;
            4'd5:    l = 4'd8;
            4'd6:    l = 4'd7;
            4'd7:    l = 4'd8;
            4'd8:    l = 4'd4;
            4'd9:    l = 4'd8;
            4'd10:   l = 4'd5;
            default: l = 4'd0;
        endcase
        return l;
    endfunction

    // character of keyword k at position pos, zero past its end
    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] pos);
        logic [63:0] w;
        logic [3:0]  l;
        logic [7:0]  ch;
        w  = kw_word(k);
        l  = kw_len(k);
        ch = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if ((4'(i) + {1'b0, pos} + 4'd1) == l) begin
                ch = w[8*i +: 8];
            end
        end
        return ch;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

// File: hdl/ckwc_lexer.sv
// ----------------------------------------------------------------------------
// ckwc_lexer
// comment, string and hash-line skipping lexer with keyword candidate narrowing
// ----------------------------------------------------------------------------
module ckwc_lexer
    import ckwc_pkg::*;
#(
    parameter int MAX_WORD     = 100,
    parameter int NUM_KEYWORDS = 11
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output word_info_t word
);

    localparam int LEN_W = $clog2(MAX_WORD);

    lex_mode_t               mode_reg, mode_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [NUM_KEYWORDS-1:0] cand_reg, cand_next;
    logic                    swl_reg, swl_next;

    logic [LEN_W-1:0]        fin_len;
    logic [NUM_KEYWORDS-1:0] fin_cand;
    logic                    fin_swl;
    logic                    done;
    logic                    restart;
    logic [LEN_W-1:0]        len_inc;
    logic [NUM_KEYWORDS-1:0] grow_cand;
    logic [NUM_KEYWORDS-1:0] start_mask;
    logic                    ident_ch;
    logic                    hit;
    logic [OUT_IDX_W-1:0]    hit_idx;

    // keywords whose character at pos equals c
    function automatic logic [NUM_KEYWORDS-1:0] match_mask(input logic [7:0] c,
                                                           input logic [LEN_W-1:0] pos);
        logic [NUM_KEYWORDS-1:0] m;
        logic                    near;
        near = (pos < LEN_W'(8));
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            m[k] = near && ({1'b0, pos[2:0]} < kw_len(4'(k)))
                   && (kw_char(4'(k), pos[2:0]) == c);
        end
        return m;
    endfunction

    assign ident_ch   = is_letter(text_byte) || is_digit(text_byte) || (text_byte == CH_UNDER);
    assign len_inc    = len_reg + 1'b1;
    assign grow_cand  = cand_reg & match_mask(text_byte, len_reg);
    assign start_mask = match_mask(text_byte, '0);

    // next lexer state and the word that ends here
    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        cand_next = cand_reg;
        swl_next  = swl_reg;
        fin_len   = len_reg;
        fin_cand  = cand_reg;
        fin_swl   = swl_reg;
        done      = 1'b0;
        restart   = 1'b0;
        if (end_of_text)
        begin
            done      = (len_reg != '0);
            mode_next = MODE_NORMAL;
            len_next  = '0;
            cand_next = '1;
            swl_next  = 1'b0;
        end
        else if (len_reg != '0)
        begin
            if (ident_ch)
            begin
                fin_cand = grow_cand;
                fin_len  = len_inc;
                if (len_inc == LEN_W'(MAX_WORD - 1))
                begin
                    // word limit reached, report and start afresh
                    done      = 1'b1;
                    len_next  = '0;
                    cand_next = '1;
                    swl_next  = 1'b0;
                end
                else
                begin
                    len_next  = len_inc;
                    cand_next = grow_cand;
                end
            end
            else
            begin
                done      = 1'b1;
                len_next  = '0;
                cand_next = '1;
                swl_next  = 1'b0;
                restart   = 1'b1;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_SLASH:
                begin
                    if (text_byte == CH_SLASH)
                        mode_next = MODE_LINE;
                    else if (text_byte == CH_STAR)
                        mode_next = MODE_BLOCK;
                    else
                        restart = 1'b1;
                end
                MODE_LINE, MODE_HASH:
                begin
                    if (text_byte == CH_NEWLINE)
                        mode_next = MODE_NORMAL;
                end
                MODE_BLOCK:
                begin
                    if (text_byte == CH_STAR)
                        mode_next = MODE_STAR;
                end
                MODE_STAR:
                begin
                    // a run of stars stays here until a slash closes the comment
                    if (text_byte == CH_SLASH)
                        mode_next = MODE_NORMAL;
                    else if (text_byte != CH_STAR)
                        mode_next = MODE_BLOCK;
                end
                MODE_STRING:
                begin
                    if (text_byte == CH_QUOTE)
                        mode_next = MODE_NORMAL;
                end
                default:
                begin
                    restart = 1'b1;
                end
            endcase
        end

        // byte lexed as normal text
        if (restart)
        begin
            if (text_byte == CH_SLASH)
                mode_next = MODE_SLASH;
            else if (text_byte == CH_QUOTE)
                mode_next = MODE_STRING;
            else if (text_byte == CH_HASH)
                mode_next = MODE_HASH;
            else
                mode_next = MODE_NORMAL;
            if (is_letter(text_byte) || (text_byte == CH_UNDER))
            begin
                cand_next = start_mask;
                swl_next  = is_letter(text_byte);
                len_next  = LEN_W'(1);
            end
        end
    end

    // keyword match, lowest index wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
            if (fin_swl && fin_cand[i] && (fin_len == LEN_W'(kw_len(4'(i))))) begin
                hit     = 1'b1;
                hit_idx = OUT_IDX_W'(i);
            end
        end
    end

    assign word.done = done;
    assign word.hit  = hit;
    assign word.idx  = hit_idx;
    assign word.len  = OUT_LEN_W'(fin_len);

    // lexer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            len_reg  <= '0;
            cand_reg <= '1;
            swl_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            cand_reg <= cand_next;
            swl_reg  <= swl_next;
        end
    end

endmodule

// File: hdl/ckwc_tally_mem.sv
// ----------------------------------------------------------------------------
// ckwc_tally_mem
// keyword count store, one write and one registered read port
// ----------------------------------------------------------------------------
module ckwc_tally_mem
#(
    parameter int DEPTH = 11,
    parameter int WIDTH = 16
)
(
    input  logic                                   clk,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // read port, new data forwarded on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
                rd_data_reg <= wr_data;
            else
                rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/c_source_keyword_counter_core.sv
// ----------------------------------------------------------------------------
// c_source_keyword_counter_core
// c source identifier finder with saturating keyword counts
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                         | tuser       | tlast
// s_      | in  | text_byte[7:0]                             | -           | end_of_text
// m_      | out | hit, index[3:0], count[15:0], length[6:0]  | result_kind | last_result
//
// a byte that ends no identifier leaves the sequencer idle; one that ends an
// identifier goes through the read and write-back of the tally memory
// an end-of-text transaction, after the lookup when it also ends an identifier,
// sweeps one memory entry per cycle, a nonzero one only while the output is free, then the end marker
// no tally clearing pass: reset and the end marker clear the per-entry valid bits
// a stalled output holds the sequencer wherever a result waits to be loaded; no new
// input is taken until the current transaction's results are all in the output register
// ----------------------------------------------------------------------------
module c_source_keyword_counter_core
    import ckwc_pkg::*;
#(
    parameter int MAX_WORD     = 100,
    parameter int NUM_KEYWORDS = 11,
    parameter int COUNT_WIDTH  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // keyword_hit, keyword_index, keyword_count, word_length
    output logic [1:0]  m_tuser,   // result_kind
    output logic        m_tlast    // last_result
);

    localparam int ADDR_W = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_SWEEP  = 4'b0100,
        ST_FINAL  = 4'b1000
    } ctrl_state_t;

    ctrl_state_t             state_reg, state_next;
    logic                    word_hit_reg, word_hit_next;
    logic [OUT_IDX_W-1:0]    word_idx_reg, word_idx_next;
    logic [OUT_LEN_W-1:0]    word_len_reg, word_len_next;
    logic                    eot_pend_reg, eot_pend_next;
    logic [OUT_IDX_W-1:0]    sweep_reg, sweep_next;
    logic [NUM_KEYWORDS-1:0] tally_valid_reg, tally_valid_next;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic                    hit_reg, hit_next;
    logic [OUT_IDX_W-1:0]    idx_reg, idx_next;
    logic [OUT_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [OUT_LEN_W-1:0]    len_reg, len_next;
    logic                    last_reg, last_next;

    word_info_t              word;
    logic                    accept;
    logic                    out_free;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic [COUNT_WIDTH-1:0]  rd_data;
    logic                    wr_en;
    logic [COUNT_WIDTH-1:0]  wr_data;
    logic [ADDR_W-1:0]       word_addr;
    logic [ADDR_W-1:0]       sweep_addr;
    logic [COUNT_WIDTH-1:0]  word_cur;
    logic [COUNT_WIDTH-1:0]  word_inc;
    logic [COUNT_WIDTH-1:0]  sweep_cur;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    ckwc_lexer #(
        .MAX_WORD     (MAX_WORD),
        .NUM_KEYWORDS (NUM_KEYWORDS)
    ) u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .word        (word)
    );

    ckwc_tally_mem #(
        .DEPTH (NUM_KEYWORDS),
        .WIDTH (COUNT_WIDTH)
    ) u_tally (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (word_addr),
        .wr_data (wr_data)
    );

    // count read back, entries never written since clearing read as zero
    assign word_addr  = word_idx_reg[ADDR_W-1:0];
    assign sweep_addr = sweep_reg[ADDR_W-1:0];
    assign word_cur   = tally_valid_reg[word_addr] ? rd_data : '0;
    assign word_inc   = (&word_cur) ? word_cur : (word_cur + 1'b1);
    assign sweep_cur  = tally_valid_reg[sweep_addr] ? rd_data : '0;
    assign wr_data    = word_inc;

    // sequencer: lookup and write-back, count sweep, end marker
    always_comb
    begin
        state_next       = state_reg;
        word_hit_next    = word_hit_reg;
        word_idx_next    = word_idx_reg;
        word_len_next    = word_len_reg;
        eot_pend_next    = eot_pend_reg;
        sweep_next       = sweep_reg;
        tally_valid_next = tally_valid_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        kind_next        = kind_reg;
        hit_next         = hit_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        len_next         = len_reg;
        last_next        = last_reg;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    eot_pend_next = s_tlast;
                    if (word.done)
                    begin
                        word_hit_next = word.hit;
                        word_idx_next = word.idx;
                        word_len_next = word.len;
                        rd_en         = 1'b1;
                        rd_addr       = word.idx[ADDR_W-1:0];
                        state_next    = ST_LOOKUP;
                    end
                    else if (s_tlast)
                    begin
                        sweep_next = '0;
                        rd_en      = 1'b1;
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    wr_en         = word_hit_reg;
                    if (word_hit_reg)
                        tally_valid_next[word_addr] = 1'b1;
                    m_tvalid_next = 1'b1;
                    kind_next     = KIND_WORD;
                    hit_next      = word_hit_reg;
                    idx_next      = word_idx_reg;
                    cnt_next      = word_hit_reg ? OUT_CNT_W'(word_inc) : '0;
                    len_next      = word_len_reg;
                    last_next     = !eot_pend_reg;
                    if (eot_pend_reg)
                    begin
                        // first sweep read, forwarded if it hits the entry just written
                        sweep_next = '0;
                        rd_en      = 1'b1;
                        state_next = ST_SWEEP;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if ((sweep_cur == '0) || out_free)
                begin
                    if (sweep_cur != '0)
                    begin
                        m_tvalid_next = 1'b1;
                        kind_next     = KIND_REPORT;
                        hit_next      = 1'b0;
                        idx_next      = sweep_reg;
                        cnt_next      = OUT_CNT_W'(sweep_cur);
                        len_next      = '0;
                        last_next     = 1'b0;
                    end
                    if (sweep_reg == OUT_IDX_W'(NUM_KEYWORDS - 1))
                        state_next = ST_FINAL;
                    else
                    begin
                        sweep_next = sweep_reg + 1'b1;
                        rd_en      = 1'b1;
                        rd_addr    = sweep_next[ADDR_W-1:0];
                    end
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    m_tvalid_next    = 1'b1;
                    kind_next        = KIND_END;
                    hit_next         = 1'b0;
                    idx_next         = '0;
                    cnt_next         = '0;
                    len_next         = '0;
                    last_next        = 1'b1;
                    tally_valid_next = '0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            eot_pend_reg    <= 1'b0;
            sweep_reg       <= '0;
            tally_valid_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            eot_pend_reg    <= eot_pend_next;
            sweep_reg       <= sweep_next;
            tally_valid_reg <= tally_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        word_hit_reg <= word_hit_next;
        word_idx_reg <= word_idx_next;
        word_len_reg <= word_len_next;
        kind_reg     <= kind_next;
        hit_reg      <= hit_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        len_reg      <= len_next;
        last_reg     <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, len_reg, cnt_reg, idx_reg, hit_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    // sweep index stays inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (sweep_reg <= OUT_IDX_W'(NUM_KEYWORDS - 1)))
        else $error("sweep index beyond keyword store");

    // counts are cleared once the end marker is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINAL) && out_free) |=> (tally_valid_reg == '0))
        else $error("keyword counts not cleared after end marker");

    // end marker is always the final, empty result
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_END)) |-> (m_tlast && (m_tdata == '0)))
        else $error("malformed end marker");

    // report entries are never final and carry no hit or length
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_REPORT)) |-> (!m_tlast && !m_tdata[0]
                                                    && (m_tdata[27:21] == '0)))
        else $error("malformed report entry");

    // an ended identifier always goes through the tally lookup
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && word.done) |=> (state_reg == ST_LOOKUP))
        else $error("ended identifier skipped the lookup");

endmodule
